>>> rtl/table_assisted_gcd_top_macros.svh
// assertion macros used by the checker file
`ifndef TABLE_ASSISTED_GCD_TOP_MACROS_SVH
`define TABLE_ASSISTED_GCD_TOP_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define TAGCD_CHECK(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TAGCD_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/tagcd_pkg.sv
// ----------------------------------------------------------------------------
// tagcd_pkg
// shared widths, pipeline item types and the per-stage step functions
// ----------------------------------------------------------------------------
package tagcd_pkg;

   localparam int unsigned XW          = 17;
   localparam int unsigned YW          = 64;
   localparam int unsigned RW          = 63;
   localparam int unsigned KW          = 5;
   localparam int unsigned MOD_BITS    = 2;
   localparam int unsigned MOD_STAGES  = YW / MOD_BITS;
   localparam int unsigned GCD_STEPS   = 2;
   localparam int unsigned GCD_STAGES  = 17;
   localparam logic [XW-1:0] MAX_X     = 17'd65536;

   typedef struct packed {
      logic [XW-1:0] x;
      logic [YW-1:0] u;
      logic [XW-1:0] rem;
      logic          range_err;
   } mod_item_type;

   typedef struct packed {
      logic [XW-1:0] a;
      logic [XW-1:0] b;
      logic [KW-1:0] k;
      logic [RW-1:0] u;
      logic          x_zero;
      logic          range_err;
   } gcd_item_type;

   typedef struct packed {
      logic [RW-1:0] gcd_result;
      logic          range_error;
   } rsp_item_type;

   // one restoring step of u mod x
   function automatic logic [XW-1:0] mod_step(logic [XW-1:0] rem, logic nbit,
                                              logic [XW-1:0] x);
      logic [XW:0] t;
      t = {rem, nbit};
      if (t >= {1'b0, x}) begin
         t = t - {1'b0, x};
      end
      return t[XW-1:0];
   endfunction

   // one binary gcd step, holds once either operand is zero
   function automatic gcd_item_type gcd_step(gcd_item_type g);
      gcd_item_type r;
      r = g;
      if (g.a != '0 && g.b != '0) begin
         priority if (!g.a[0] && !g.b[0]) begin
            r.a = g.a >> 1;
            r.b = g.b >> 1;
            r.k = g.k + 1'b1;
         end else if (!g.a[0]) begin
            r.a = g.a >> 1;
         end else if (!g.b[0]) begin
            r.b = g.b >> 1;
         end else if (g.a >= g.b) begin
            r.a = (g.a - g.b) >> 1;
         end else begin
            r.b = (g.b - g.a) >> 1;
         end
      end
      return r;
   endfunction

endpackage

>>> rtl/table_assisted_gcd_top.sv
// ----------------------------------------------------------------------------
// table_assisted_gcd_top
// gcd of a 17-bit unsigned x and the magnitude of a signed 64-bit y
// ----------------------------------------------------------------------------
// usage
// - request channel req_valid/req_stall carries req_x_value and req_y_value;
//   a transfer happens when req_valid is high and req_stall low
// - response channel rsp_valid/rsp_stall carries rsp_gcd_result and
//   rsp_range_error, one response per request, in request order
// - x above 65536 gives range_error 1 and result 0; x zero gives |y| in
//   63 bits
// - pipeline: one input stage, 32 reduction stages computing
//   |y| mod x two bits each, 17 binary gcd stages of two steps each, and
//   one output stage
// - throughput is one request per cycle while the skid register is empty;
//   the reduction and gcd stages are fully pipelined
// - a stalled response is parked in a skid register; while it is full the
//   whole pipeline holds and req_stall is high (registered, no path from
//   rsp_stall)
// - synchronous reset clears all valid bits, the skid register's included; no
//   start-up sequence, requests are taken from the first cycle after reset
// ----------------------------------------------------------------------------
module table_assisted_gcd_top
   import tagcd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [XW-1:0]        req_x_value,
   input  logic signed [YW-1:0] req_y_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [RW-1:0]        rsp_gcd_result,
   output logic                 rsp_range_error
);

   logic         en;
   logic         in_valid_ff;
   mod_item_type in_item_ff;
   mod_item_type in_item_in;

   logic         mod_valid [0:MOD_STAGES];
   mod_item_type mod_item  [0:MOD_STAGES];
   logic         gcd_valid [0:GCD_STAGES];
   gcd_item_type gcd_item  [0:GCD_STAGES];

   logic         out_valid_ff;
   rsp_item_type out_item_ff;
   rsp_item_type out_item_in;
   logic         skid_valid_ff;
   logic         skid_valid_in;
   rsp_item_type skid_item_ff;
   logic         rsp_transfer;

   assign en = !skid_valid_ff;

   // input stage: magnitude of y and range check
   always_comb begin
      in_item_in.x         = req_x_value;
      in_item_in.u         = req_y_value[YW-1] ? (~req_y_value + 1'b1) : req_y_value;
      in_item_in.rem       = '0;
      in_item_in.range_err = req_x_value > MAX_X;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (en) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         in_item_ff <= in_item_in;
      end
   end

   assign mod_valid[0] = in_valid_ff;
   assign mod_item[0]  = in_item_ff;

   for (genvar s = 0; s < MOD_STAGES; s++) begin : g_mod
      tagcd_mod_stage #(.STAGE(s)) u_mod (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (mod_valid[s]),
         .in_item   (mod_item[s]),
         .out_valid (mod_valid[s+1]),
         .out_item  (mod_item[s+1])
      );
   end

   // gcd(x, u) = gcd(x, u mod x)
   assign gcd_valid[0]          = mod_valid[MOD_STAGES];
   assign gcd_item[0].a         = mod_item[MOD_STAGES].x;
   assign gcd_item[0].b         = mod_item[MOD_STAGES].rem;
   assign gcd_item[0].k         = '0;
   assign gcd_item[0].u         = mod_item[MOD_STAGES].u[RW-1:0];
   assign gcd_item[0].x_zero    = mod_item[MOD_STAGES].x == '0;
   assign gcd_item[0].range_err = mod_item[MOD_STAGES].range_err;

   for (genvar s = 0; s < GCD_STAGES; s++) begin : g_gcd
      tagcd_gcd_stage u_gcd (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (gcd_valid[s]),
         .in_item   (gcd_item[s]),
         .out_valid (gcd_valid[s+1]),
         .out_item  (gcd_item[s+1])
      );
   end

   always_comb begin
      out_item_in.range_error = gcd_item[GCD_STAGES].range_err;
      priority if (gcd_item[GCD_STAGES].range_err) begin
         out_item_in.gcd_result = '0;
      end else if (gcd_item[GCD_STAGES].x_zero) begin
         out_item_in.gcd_result = gcd_item[GCD_STAGES].u;
      end else begin
         out_item_in.gcd_result =
            {{(RW-XW){1'b0}}, gcd_item[GCD_STAGES].a | gcd_item[GCD_STAGES].b}
            << gcd_item[GCD_STAGES].k;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= gcd_valid[GCD_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_item_ff <= out_item_in;
      end
   end

   // skid: park the output when it is stalled, hold the pipeline meanwhile
   assign rsp_transfer = rsp_valid && !rsp_stall;

   always_comb begin
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (rsp_transfer) begin
            skid_valid_in = 1'b0;
         end
      end else if (out_valid_ff && rsp_stall) begin
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_valid_ff) begin
         skid_item_ff <= out_item_ff;
      end
   end

   assign req_stall       = skid_valid_ff;
   assign rsp_valid       = skid_valid_ff || out_valid_ff;
   assign rsp_gcd_result  = skid_valid_ff ? skid_item_ff.gcd_result : out_item_ff.gcd_result;
   assign rsp_range_error = skid_valid_ff ? skid_item_ff.range_error
                                          : out_item_ff.range_error;

endmodule

>>> rtl/tagcd_mod_stage.sv
// ----------------------------------------------------------------------------
// tagcd_mod_stage
// one register stage of the |y| mod x reduction, MOD_BITS bits per stage
// ----------------------------------------------------------------------------
module tagcd_mod_stage
   import tagcd_pkg::*;
#(
   parameter int unsigned STAGE = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  mod_item_type in_item,
   output logic         out_valid,
   output mod_item_type out_item
);

   logic         valid_ff;
   mod_item_type item_ff;
   mod_item_type item_in;

   always_comb begin
      item_in = in_item;
      for (int j = 0; j < MOD_BITS; j++) begin
         item_in.rem = mod_step(item_in.rem,
                                in_item.u[6'(YW - 1 - STAGE * MOD_BITS - j)],
                                in_item.x);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

>>> rtl/tagcd_gcd_stage.sv
// ----------------------------------------------------------------------------
// tagcd_gcd_stage
// one register stage of the binary gcd, GCD_STEPS steps per stage
// ----------------------------------------------------------------------------
module tagcd_gcd_stage
   import tagcd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         en,
   input  logic         in_valid,
   input  gcd_item_type in_item,
   output logic         out_valid,
   output gcd_item_type out_item
);

   logic         valid_ff;
   gcd_item_type item_ff;
   gcd_item_type item_in;

   always_comb begin
      item_in = in_item;
      for (int j = 0; j < GCD_STEPS; j++) begin
         item_in = gcd_step(item_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

>>> rtl/tagcd_checker.sv
// ----------------------------------------------------------------------------
// tagcd_checker
// port-level checks on the gcd block, bound to the top level
// ----------------------------------------------------------------------------
`include "table_assisted_gcd_top_macros.svh"

module tagcd_checker
   import tagcd_pkg::*;
(
   input logic          clock,
   input logic          reset,
   input logic          req_stall,
   input logic          rsp_valid,
   input logic          rsp_stall,
   input logic [RW-1:0] rsp_gcd_result,
   input logic          rsp_range_error
);

   `TAGCD_CHECK_NEXT(a_rsp_valid_held, rsp_valid && rsp_stall, rsp_valid,
      "response dropped while stalled")
   `TAGCD_CHECK_NEXT(a_rsp_data_held, rsp_valid && rsp_stall,
      $stable(rsp_gcd_result) && $stable(rsp_range_error),
      "response changed while stalled")
   `TAGCD_CHECK(a_range_zero, rsp_valid && rsp_range_error, rsp_gcd_result == '0,
      "range error with nonzero result")
   `TAGCD_CHECK(a_stall_cause, req_stall, $past(rsp_valid && rsp_stall),
      "request stalled without a stalled response")

endmodule

bind table_assisted_gcd_top tagcd_checker u_tagcd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_gcd_result  (rsp_gcd_result),
   .rsp_range_error (rsp_range_error)
);

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// checks table_assisted_gcd_top against its own gcd predictor: a directed
// table of edge cases, then random queries with idling on both channels
// ----------------------------------------------------------------------------
module tb
   import tagcd_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned N_RANDOM   = 1830;
   localparam int unsigned TAIL_WAIT  = 80;
   localparam int unsigned CYCLE_CAP  = 400000;
   localparam logic [YW-1:0] Y_MIN    = 64'h8000_0000_0000_0000;
   localparam logic [YW-1:0] Y_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef struct {
      logic [RW-1:0] gcd_result;
      logic          range_error;
   } gcd_answer_type;

   typedef struct {
      logic [XW-1:0] x;
      logic [YW-1:0] y;
      bit            typed;
      logic [RW-1:0] gcd_result;
      logic          range_error;
   } query_row_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [XW-1:0]        req_x_value;
   logic signed [YW-1:0] req_y_value;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [RW-1:0]        rsp_gcd_result;
   logic                 rsp_range_error;

   gcd_answer_type pending_answers[$];
   query_row_type  query_table[$];
   int unsigned    mismatches;
   int unsigned    cycles = 0;
   bit             quiet;

   table_assisted_gcd_top dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_x_value    (req_x_value),
      .req_y_value    (req_y_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_gcd_result (rsp_gcd_result),
      .rsp_range_error(rsp_range_error)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // gcd of x and |y| as the block defines it
   function automatic gcd_answer_type gcd_of(logic [XW-1:0] x, logic [YW-1:0] y);
      gcd_answer_type r;
      logic [YW-1:0]  mag;
      logic [YW-1:0]  p;
      logic [YW-1:0]  q;
      logic [YW-1:0]  t;
      mag = y[YW-1] ? (64'd0 - y) : y;
      r.range_error = 1'b0;
      if (x > MAX_X) begin
         r.gcd_result  = '0;
         r.range_error = 1'b1;
      end else if (x == '0) begin
         r.gcd_result = mag[RW-1:0];
      end else begin
         p = {47'd0, x};
         q = mag % p;
         while (q != 0) begin
            t = p % q;
            p = q;
            q = t;
         end
         r.gcd_result = p[RW-1:0];
      end
      return r;
   endfunction

   function automatic logic [YW-1:0] random_y();
      logic [YW-1:0] y;
      y = {$urandom, $urandom};
      if (y == Y_MIN) y = 64'd1;
      return y;
   endfunction

   task automatic add_row(logic [XW-1:0] x, logic [YW-1:0] y, bit typed,
                          logic [RW-1:0] g, logic e);
      query_row_type row;
      row.x = x;
      row.y = y;
      row.typed = typed;
      row.gcd_result = g;
      row.range_error = e;
      query_table = {query_table, row};
   endtask

   task automatic send_query(logic [XW-1:0] x, logic [YW-1:0] y);
      while (!quiet && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_x_value <= x;
      req_y_value <= y;
      do @(posedge clock); while (req_stall);
   endtask

   // acceptance on the request side, sampled before the edge updates
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         pending_answers = {pending_answers, gcd_of(req_x_value, req_y_value)};
      end
   end

   always @(posedge clock) begin
      gcd_answer_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 22);
         if (rsp_valid && !rsp_stall) begin
            if (pending_answers.size() == 0) begin
               $display("%0t: response with nothing outstanding: result %0d error %0b",
                        $realtime, rsp_gcd_result, rsp_range_error);
               mismatches++;
            end else begin
               want = pending_answers.pop_front();
               if (want.gcd_result !== rsp_gcd_result) begin
                  $display("%0t: gcd_result expected %0d actual %0d", $realtime,
                           want.gcd_result, rsp_gcd_result);
                  mismatches++;
               end
               if (want.range_error !== rsp_range_error) begin
                  $display("%0t: range_error expected %0b actual %0b", $realtime,
                           want.range_error, rsp_range_error);
                  mismatches++;
               end
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      logic [XW-1:0]  x;
      logic [YW-1:0]  y;
      gcd_answer_type got;
      int unsigned    pick;
      mismatches  = 0;
      quiet       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_x_value = '0;
      req_y_value = '0;

      add_row(17'd0,     64'd0,                  1, 63'd0,      1'b0);
      add_row(17'd0,     Y_MAX,                  1, Y_MAX[RW-1:0], 1'b0);
      add_row(17'd0,     64'd0 - Y_MAX,          1, Y_MAX[RW-1:0], 1'b0);
      add_row(17'd0,     Y_MIN,                  1, 63'd0,      1'b0);
      add_row(17'd1,     Y_MAX,                  1, 63'd1,      1'b0);
      add_row(17'd65536, 64'd3 << 20,            1, 63'd65536,  1'b0);
      add_row(17'd65536, Y_MIN,                  1, 63'd65536,  1'b0);
      add_row(17'd65537, 64'd12,                 1, 63'd0,      1'b1);
      add_row(17'd131071, 64'hFFFF_FFFF_FFFF_FFFF, 1, 63'd0,    1'b1);
      add_row(17'd2,     64'd0,                  1, 63'd2,      1'b0);
      add_row(17'd65521, 64'd65521 * 7,          1, 63'd65521,  1'b0);
      add_row(17'd65521, 64'd0 - 64'd65520,      0, '0, 1'b0);
      add_row(17'd65535, 64'd0 - 64'd21845,      0, '0, 1'b0);
      add_row(17'd62500, 64'd1000000000000,      0, '0, 1'b0);
      add_row(17'd256,   64'd0 - 64'd6144,       0, '0, 1'b0);
      add_row(17'd60060, 64'd123456789012,       0, '0, 1'b0);
      add_row(17'd65534, 64'd2 * 32767 * 999,    0, '0, 1'b0);
      add_row(17'd255,   64'd1,                  0, '0, 1'b0);
      add_row(17'd30030, Y_MAX,                  0, '0, 1'b0);
      add_row(17'd4096,  64'd0 - 64'd1024,       0, '0, 1'b0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (query_table[i]) begin
         if (query_table[i].typed) begin
            got = gcd_of(query_table[i].x, query_table[i].y);
            if (got.gcd_result !== query_table[i].gcd_result ||
                got.range_error !== query_table[i].range_error) begin
               $display("%0t: table row %0d expected %0d/%0b predicted %0d/%0b", $realtime,
                        i, query_table[i].gcd_result, query_table[i].range_error,
                        got.gcd_result, got.range_error);
               mismatches++;
            end
         end
         send_query(query_table[i].x, query_table[i].y);
      end

      for (int n = 0; n < N_RANDOM; n++) begin
         quiet = (n >= 600 && n < 900);
         // hold off until the pipeline has drained
         if (n == 1200) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_answers.size() != 0) @(posedge clock);
         end
         pick = $urandom_range(99);
         if (pick < 10)      x = 17'($urandom_range(16));
         else if (pick < 70) x = 17'($urandom_range(65536));
         else if (pick < 75) x = 17'd65536 - 17'($urandom_range(3));
         else                x = 17'($urandom_range(131071));
         pick = $urandom_range(99);
         if (pick < 45 && x != 0) begin
            y = {47'd0, x} * 64'($urandom_range(1 << 20))
                * ($urandom_range(1) ? 64'd1 : 64'd3);
            if ($urandom_range(1)) y = 64'd0 - y;
         end else if (pick < 55) begin
            y = 64'($urandom_range(255));
            if ($urandom_range(1)) y = 64'd0 - y;
         end else begin
            y = random_y();
         end
         send_query(x, y);
      end
      req_valid <= 1'b0;
      quiet = 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
